// ----- design/cylindrical_pair_force_top_macros.svh -----
// ---------------------------------------------------------------------------
// Cylindrical pair force: assertion macros
// Shared property forms used by the pair force pipeline checks.
// ---------------------------------------------------------------------------
`ifndef CYLINDRICAL_PAIR_FORCE_TOP_MACROS_SVH
`define CYLINDRICAL_PAIR_FORCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CPF_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CPF_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cpf_pkg.sv -----
// ---------------------------------------------------------------------------
// Cylindrical pair force package
// Constants, stage map, pipeline word type and cosine series tables.
// ---------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

    localparam int CoordFracBits = 16;

    localparam logic [31:0] AngPi     = 32'd843314857;
    localparam logic [31:0] AngTwoPi  = 32'd1686629714;
    localparam logic [31:0] AngFourPi = 32'd3373259428;
    localparam logic [31:0] AngHalfPi = 32'd421657428;
    localparam logic [30:0] UnitQ30   = 31'h4000_0000;

    localparam int NumCos    = 7;
    localparam int CosBase   = 4;
    localparam int StRp1     = CosBase + 3 * NumCos;
    localparam int StRp2     = StRp1 + 1;
    localparam int StSum     = StRp2 + 1;
    localparam int SqBase    = StSum + 1;
    localparam int SqSteps   = 32;
    localparam int StDist    = SqBase + SqSteps;
    localparam int QdBase    = StDist + 1;
    localparam int QdSteps   = 64;
    localparam int MulBase   = QdBase + QdSteps;
    localparam int NumMul    = 4;
    localparam int StG       = MulBase + 2 * NumMul;
    localparam int StWa      = StG + 1;
    localparam int StWb      = StWa + 1;
    localparam int FdBase    = StWb + 1;
    localparam int FdSteps   = 32;
    localparam int StFin     = FdBase + FdSteps;
    localparam int NumStages = StFin + 1;

    typedef enum logic [1:0] {
        RegCutoff,
        RegEqLen,
        RegStrength,
        RegForceLimit
    } t_reg_idx;

    typedef struct packed {
        logic [30:0]      ra;
        logic [30:0]      rb;
        logic [31:0]      dang;
        logic [31:0]      dh;
        logic [61:0]      sqa;
        logic [61:0]      sqb;
        logic [61:0]      pr;
        logic [63:0]      dh2;
        logic [30:0]      ax;
        logic             neg;
        logic [62:0]      sq;
        logic [31:0]      x2;
        logic [30:0]      ct;
        logic [31:0]      cp;
        logic [31:0]      cs;
        logic [59:0]      ph;
        logic [31:0]      pl;
        logic [63:0]      hd2;
        logic             carry;
        logic [63:0]      sv;
        logic [63:0]      sres;
        logic [31:0]      sep;
        logic             act;
        logic             zd;
        logic             sz;
        logic [31:0]      qrem;
        logic [4:0][63:0] qp;
        logic [3:0][63:0] pp;
        logic             povf;
        logic [63:0]      g;
        logic             gpos;
        logic             fovf;
        logic [63:0]      frem;
        logic [31:0]      nlo;
        logic [31:0]      fq;
        logic [31:0]      frc;
        logic             clp;
    } t_pl;

    function automatic logic [7:0] cos_k(input int i);
        logic [7:0] k;
        case (i)
            0:       k = 8'd182;
            1:       k = 8'd132;
            2:       k = 8'd90;
            3:       k = 8'd56;
            4:       k = 8'd30;
            5:       k = 8'd12;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

    // Reciprocals floor(2^32 / k) of the series divisors; entry 0 lies below that value.
    function automatic logic [31:0] cos_m(input int i);
        logic [31:0] m;
        case (i)
            0:       m = 32'd23598397;
            1:       m = 32'd32537631;
            2:       m = 32'd47721858;
            3:       m = 32'd76695844;
            4:       m = 32'd143165576;
            5:       m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- design/cylindrical_pair_force_top.sv -----
// ---------------------------------------------------------------------------
// Cylindrical pair force top level
// Lennard-Jones style pair force with cutoff for particles given in
// cylindrical coordinates, as one long stream pipeline.
// ---------------------------------------------------------------------------
// The input stream carries one particle pair per word; the output stream
// carries its distance, the clamped force and a clamp flag.
// Four registers on the APB port hold cutoff, equilibrium length, well
// strength and force limit; write them only while no word is in flight.
// The pipeline has 169 register stages; one pair is taken every cycle while
// the output is not stalled. The depth is set by the 32 square root steps,
// the 64 steps of the ratio division and the 32 steps of the force division,
// one step per stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis tready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module cylindrical_pair_force_top #(
    parameter int COORD_FRAC_BITS = cpf_pkg::CoordFracBits
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // radius_a[30:0] angle_a[62:31] height_a[94:63] radius_b[125:95]
    // angle_b[157:126] height_b[189:158] zero[191:190]
    input  wire logic [191:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // distance[31:0] pair_force[63:32]
    output logic [63:0]       o_m_axis_tdata,
    // clamped[0]
    output logic              o_m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cpf_pkg::*;

    localparam int DenShift = 32 - COORD_FRAC_BITS;
    localparam int DenW     = 32 + DenShift;

    logic [31:0] r_cutoff;
    logic [31:0] r_eq_len;
    logic [30:0] r_strength;
    logic [30:0] r_force_limit;

    t_pl  r_pl [NumStages];
    t_pl  n_pl [NumStages];
    logic [NumStages-1:0] r_vld;
    logic en;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff      <= 32'd0;
            r_eq_len      <= 32'd65536;
            r_strength    <= 31'd65536;
            r_force_limit <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[3:2]))
                RegCutoff:     r_cutoff      <= pwdata;
                RegEqLen:      r_eq_len      <= pwdata;
                RegStrength:   r_strength    <= pwdata[30:0];
                RegForceLimit: r_force_limit <= pwdata[30:0];
                default:       r_cutoff      <= r_cutoff;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            RegCutoff:     prdata = r_cutoff;
            RegEqLen:      prdata = r_eq_len;
            RegStrength:   prdata = {1'b0, r_strength};
            RegForceLimit: prdata = {1'b0, r_force_limit};
            default:       prdata = 32'd0;
        endcase
    end

    assign en              = !r_vld[NumStages-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    for (genvar k = 0; k < NumStages; k++) begin : g_st
        t_pl n_st;
        assign n_pl[k] = n_st;

        if (k == 0) begin : g_in
            always_comb begin
                logic signed [32:0] da;
                logic signed [32:0] dz;
                n_st    = '0;
                n_st.ra = i_s_axis_tdata[30:0];
                n_st.rb = i_s_axis_tdata[125:95];
                da = {i_s_axis_tdata[62], i_s_axis_tdata[62:31]}
                   - {i_s_axis_tdata[157], i_s_axis_tdata[157:126]};
                dz = {i_s_axis_tdata[94], i_s_axis_tdata[94:63]}
                   - {i_s_axis_tdata[189], i_s_axis_tdata[189:158]};
                n_st.dang = da[32] ? 32'(-da) : da[31:0];
                n_st.dh   = dz[32] ? 32'(-dz) : dz[31:0];
            end
        end else if (k == 1) begin : g_mod
            always_comb begin
                t_pl p;
                logic [31:0] d;
                p    = r_pl[k-1];
                n_st = p;
                d    = p.dang;
                if (d >= AngFourPi) d = d - AngFourPi;
                if (d >= AngTwoPi) d = d - AngTwoPi;
                n_st.ax  = d[30:0];
                n_st.sqa = 62'(p.ra) * 62'(p.ra);
                n_st.sqb = 62'(p.rb) * 62'(p.rb);
                n_st.pr  = 62'(p.ra) * 62'(p.rb);
                n_st.dh2 = 64'(p.dh) * 64'(p.dh);
            end
        end else if (k == 2) begin : g_fold
            always_comb begin
                t_pl p;
                logic [30:0] x;
                p        = r_pl[k-1];
                n_st     = p;
                x        = p.ax;
                n_st.neg = 1'b0;
                if (x > AngPi[30:0]) x = AngTwoPi[30:0] - x;
                if (x > AngHalfPi[30:0]) begin
                    x        = AngPi[30:0] - x;
                    n_st.neg = 1'b1;
                end
                n_st.ax = x;
                n_st.sq = 63'(p.sqa) + 63'(p.sqb);
            end
        end else if (k == 3) begin : g_x2
            always_comb begin
                t_pl p;
                logic [30:0] xq;
                logic [61:0] prod;
                p       = r_pl[k-1];
                n_st    = p;
                xq      = {p.ax[28:0], 2'b00};
                prod    = 62'(xq) * 62'(xq);
                n_st.x2 = prod[61:30];
                n_st.ct = UnitQ30;
            end
        end else if (k < StRp1) begin : g_cos
            localparam int CosIt = (k - CosBase) / 3;
            localparam int CosPh = (k - CosBase) % 3;
            always_comb begin
                t_pl p;
                logic [62:0] prod;
                logic [63:0] rprod;
                logic [39:0] chk;
                logic [39:0] rem;
                logic [31:0] s;
                p     = r_pl[k-1];
                n_st  = p;
                prod  = 63'(p.x2) * 63'(p.ct);
                rprod = 64'(p.cp) * 64'(cos_m(CosIt));
                chk   = 40'(p.cs) * 40'(cos_k(CosIt));
                rem   = 40'(p.cp) - chk;
                s     = p.cs + ((rem >= 40'(cos_k(CosIt))) ? 32'd1 : 32'd0);
                if (CosPh == 0) begin
                    n_st.cp = prod[61:30];
                end else if (CosPh == 1) begin
                    n_st.cs = rprod[63:32];
                end else begin
                    n_st.ct = (s > 32'(UnitQ30)) ? 31'd0 : UnitQ30 - s[30:0];
                end
            end
        end else if (k == StRp1) begin : g_rp1
            always_comb begin
                t_pl p;
                logic [62:0] prod;
                p       = r_pl[k-1];
                n_st    = p;
                n_st.ph = 60'(p.pr[61:32]) * 60'(p.ct);
                prod    = 63'(p.pr[31:0]) * 63'(p.ct);
                n_st.pl = prod[61:30];
            end
        end else if (k == StRp2) begin : g_rp2
            always_comb begin
                t_pl p;
                logic [63:0] s;
                logic [63:0] t2;
                logic [63:0] sq;
                p    = r_pl[k-1];
                n_st = p;
                s    = (64'(p.ph) << 2) + 64'(p.pl);
                t2   = s << 1;
                sq   = 64'(p.sq);
                if (p.neg) n_st.hd2 = sq + t2;
                else if (sq >= t2) n_st.hd2 = sq - t2;
                else n_st.hd2 = t2 - sq;
            end
        end else if (k == StSum) begin : g_sum
            always_comb begin
                t_pl p;
                logic [64:0] tot;
                p          = r_pl[k-1];
                n_st       = p;
                tot        = 65'(p.hd2) + 65'(p.dh2);
                n_st.carry = tot[64];
                n_st.sv    = tot[63:0];
                n_st.sres  = 64'd0;
            end
        end else if (k < StDist) begin : g_sqrt
            localparam int SqJ = k - SqBase;
            localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * SqJ);
            always_comb begin
                t_pl p;
                logic [63:0] tr;
                p    = r_pl[k-1];
                n_st = p;
                tr   = p.sres + SqBit;
                if (p.sv >= tr) begin
                    n_st.sv   = p.sv - tr;
                    n_st.sres = (p.sres >> 1) + SqBit;
                end else begin
                    n_st.sres = p.sres >> 1;
                end
            end
        end else if (k == StDist) begin : g_dist
            always_comb begin
                t_pl p;
                logic [31:0] d;
                p          = r_pl[k-1];
                n_st       = p;
                d          = p.carry ? 32'hFFFF_FFFF : p.sres[31:0];
                n_st.sep   = d;
                n_st.act   = d < r_cutoff;
                n_st.zd    = d == 32'd0;
                n_st.sz    = r_strength == 31'd0;
                n_st.qrem  = 32'd0;
                n_st.qp    = '0;
                n_st.povf  = 1'b0;
            end
        end else if (k < MulBase) begin : g_qdiv
            localparam int QdI   = QdSteps - 1 - (k - QdBase);
            localparam int EqIdx = (QdI >= 32) ? QdI - 32 : 0;
            always_comb begin
                t_pl p;
                logic [32:0] r2;
                logic        qb;
                p    = r_pl[k-1];
                n_st = p;
                r2   = {p.qrem, (QdI >= 32) && r_eq_len[EqIdx]};
                qb   = r2 >= {1'b0, p.sep};
                if (qb) r2 = r2 - {1'b0, p.sep};
                n_st.qrem  = r2[31:0];
                n_st.qp[0] = {p.qp[0][62:0], qb};
            end
        end else if (k < StG) begin : g_mul
            localparam int MulM  = (k - MulBase) / 2;
            localparam int MulPh = (k - MulBase) % 2;
            always_comb begin
                t_pl p;
                logic [63:0]  a;
                logic [63:0]  b;
                logic [127:0] full;
                p    = r_pl[k-1];
                n_st = p;
                a    = p.qp[MulM];
                b    = (MulM < 2) ? p.qp[0] : p.qp[MulM];
                full = 128'(p.pp[0]) + (128'(p.pp[1]) << 32)
                     + (128'(p.pp[2]) << 32) + (128'(p.pp[3]) << 64);
                if (MulPh == 0) begin
                    n_st.pp[0] = 64'(a[31:0]) * 64'(b[31:0]);
                    n_st.pp[1] = 64'(a[31:0]) * 64'(b[63:32]);
                    n_st.pp[2] = 64'(a[63:32]) * 64'(b[31:0]);
                    n_st.pp[3] = 64'(a[63:32]) * 64'(b[63:32]);
                end else begin
                    if (full[127:96] != 32'd0) begin
                        n_st.povf       = 1'b1;
                        n_st.qp[MulM+1] = 64'hFFFF_FFFF_FFFF_FFFF;
                    end else begin
                        n_st.qp[MulM+1] = full[95:32];
                        if ((MulM == NumMul - 1) && full[95]) n_st.povf = 1'b1;
                    end
                end
            end
        end else if (k == StG) begin : g_g
            always_comb begin
                t_pl p;
                logic [63:0] twice;
                p     = r_pl[k-1];
                n_st  = p;
                twice = {p.qp[4][62:0], 1'b0};
                if (twice >= p.qp[3]) begin
                    n_st.g    = twice - p.qp[3];
                    n_st.gpos = 1'b1;
                end else begin
                    n_st.g    = p.qp[3] - twice;
                    n_st.gpos = 1'b0;
                end
            end
        end else if (k == StWa) begin : g_wa
            always_comb begin
                t_pl p;
                logic [35:0] a;
                p          = r_pl[k-1];
                n_st       = p;
                a          = (36'(r_strength) << 4) + (36'(r_strength) << 3);
                n_st.pp[0] = 64'(a[31:0]) * 64'(p.g[31:0]);
                n_st.pp[1] = 64'(a[31:0]) * 64'(p.g[63:32]);
                n_st.pp[2] = 64'(a[35:32]) * 64'(p.g[31:0]);
                n_st.pp[3] = 64'(a[35:32]) * 64'(p.g[63:32]);
            end
        end else if (k == StWb) begin : g_wb
            always_comb begin
                t_pl p;
                logic [99:0]     num;
                logic [DenW-1:0] den;
                p         = r_pl[k-1];
                n_st      = p;
                num       = 100'(p.pp[0]) + (100'(p.pp[1]) << 32)
                          + (100'(p.pp[2]) << 32) + (100'(p.pp[3]) << 64);
                den       = DenW'(p.sep) << DenShift;
                n_st.fovf = num[99:32] >= 68'(den);
                n_st.frem = 64'(num[DenW+31:32]);
                n_st.nlo  = num[31:0];
                n_st.fq   = 32'd0;
            end
        end else if (k < StFin) begin : g_fdiv
            localparam int FdI = FdSteps - 1 - (k - FdBase);
            always_comb begin
                t_pl p;
                logic [DenW-1:0] den;
                logic [DenW:0]   r2;
                logic            qb;
                p    = r_pl[k-1];
                n_st = p;
                den  = DenW'(p.sep) << DenShift;
                r2   = {p.frem[DenW-1:0], p.nlo[FdI]};
                qb   = r2 >= {1'b0, den};
                if (qb) r2 = r2 - {1'b0, den};
                n_st.frem = 64'(r2[DenW-1:0]);
                n_st.fq   = {p.fq[30:0], qb};
            end
        end else begin : g_fin
            always_comb begin
                t_pl p;
                logic [31:0] lim;
                logic [31:0] mag;
                logic        pos;
                logic        flg;
                p    = r_pl[k-1];
                n_st = p;
                lim  = {1'b0, r_force_limit};
                mag  = 32'd0;
                pos  = 1'b1;
                flg  = 1'b0;
                priority if (!p.act) begin
                    mag = 32'd0;
                end else if (p.zd) begin
                    mag = lim;
                    flg = 1'b1;
                end else if (p.sz) begin
                    mag = 32'd0;
                end else if (p.povf) begin
                    mag = lim;
                    flg = 1'b1;
                end else if (p.fovf || (p.fq > lim)) begin
                    mag = lim;
                    flg = 1'b1;
                    pos = p.gpos;
                end else begin
                    mag = p.fq;
                    pos = p.gpos;
                end
                n_st.frc = pos ? mag : 32'd0 - mag;
                n_st.clp = flg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NumStages-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NumStages; s++) begin
                r_pl[s] <= n_pl[s];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NumStages-1];
    assign o_m_axis_tdata  = {r_pl[StFin].frc, r_pl[StFin].sep};
    assign o_m_axis_tuser  = r_pl[StFin].clp;

`include "cylindrical_pair_force_top_macros.svh"

    `CPF_CHECK_NEXT(a_accept_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[0],
        "accepted word did not enter the first stage")
    `CPF_CHECK(a_clamp_is_limit, o_m_axis_tvalid && o_m_axis_tuser,
        (o_m_axis_tdata[63:32] == {1'b0, r_force_limit}) ||
        (o_m_axis_tdata[63:32] == (32'd0 - {1'b0, r_force_limit})),
        "clamped force is not the force limit")
    `CPF_CHECK(a_force_in_cutoff, o_m_axis_tvalid && (o_m_axis_tdata[63:32] != 32'd0),
        o_m_axis_tdata[31:0] < r_cutoff, "nonzero force at or beyond cutoff")

endmodule

`default_nettype wire
